// ===== hw/rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// Types, codes and constants shared by the fan PWM and tachometer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

	localparam int FAN_CHANNELS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int KIND_W   = 2;
	localparam int ADDR_W   = 3;
	localparam int VALUE_W  = 16;
	localparam int PCT_W    = 7;
	localparam int DUTY_W   = 8;
	localparam int PPR_W    = 4;
	localparam int WIN_W    = 16;
	localparam int CNT_W    = 16;
	localparam int NUM_W    = 32;
	localparam int DEN_W    = PPR_W + WIN_W;
	localparam int PROD_W   = 15;
	localparam int CFG_IDX_W = 1;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PULSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] REPORT_DUTY  = 2'd0;
	localparam logic [KIND_W-1:0] REPORT_SPEED = 2'd1;
	localparam logic [KIND_W-1:0] REPORT_READ  = 2'd2;

	// queued operations
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_PULSE  = 2'd1;
	localparam logic [1:0] OP_WINDOW = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 1'd1;

	localparam logic [PPR_W-1:0] PPR_RESET = 4'd2;
	localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;

	localparam logic [VALUE_W-1:0] PCT_MAX    = 16'd100;
	localparam logic [CNT_W-1:0]   RPM_SCALE  = 16'd60000;
	localparam logic [7:0]         DUTY_MUL   = 8'd255;
	localparam logic [5:0]         DUTY_ROUND = 6'd50;
	// floor(x/100) for x < 2^15 as (x * 5243) >> 19
	localparam logic [12:0]        DUTY_RECIP = 13'd5243;
	localparam int                 DUTY_SHIFT = 19;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address;
		logic [VALUE_W-1:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  report_kind;
		logic [ADDR_W-1:0]  channel_or_address;
		logic [VALUE_W-1:0] data;
		logic [DUTY_W-1:0]  pwm_duty;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [PCT_W-1:0]  pct;
	} cmd_t;

	typedef struct packed {
		logic [PPR_W-1:0] pulses_per_rev;
		logic [WIN_W-1:0] window_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fan_pwm_tacho_controller.sv =====
// ----------------------------------------------------------------------------
// fan_pwm_tacho_controller
// Fan PWM setpoints with tachometer speed measurement over a tick window.
// ----------------------------------------------------------------------------
//  channel  signals                               transfer when
//  in       in_valid, in_stall, in_item           in_valid && !in_stall
//  out      out_valid, out_stall, out_item        out_valid && !out_stall
//  cfg      cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//
//  Pulses and reads are done straight from the queue head in the back end, duty
//  updates pass through a duty state; plain ticks and ignored items end in the
//  front. On a window end each fan channel goes through load, check, the 16-step
//  shift-subtract divider and emit; a saturated speed skips the divider.
//  The front stalls only when the 4-entry command queue is full.
//  Reset clears setpoints, counters, speeds, the window timer and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_pwm_tacho_controller #(
	parameter int FAN_CHANNELS = fpt_pkg::FAN_CHANNELS_DEF,
	parameter int QUEUE_DEPTH  = fpt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire fpt_pkg::in_item_t                in_item,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output fpt_pkg::out_item_t                    out_item,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpt_pkg::VALUE_W-1:0]      cfg_data
);
	import fpt_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;
	logic q_pop;
	cmd_t q_head;
	logic q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_rev <= PPR_RESET;
			cfg_q.window_ms      <= WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PULSES_PER_REV) begin
				cfg_q.pulses_per_rev <= cfg_data[PPR_W-1:0];
			end else if (cfg_index == CFG_WINDOW_MS) begin
				cfg_q.window_ms <= cfg_data;
			end
		end
	end

	fpt_front #(
		.FAN_CHANNELS(FAN_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.q_full   (q_full)
	);

	fpt_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	fpt_back #(
		.FAN_CHANNELS(FAN_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/fpt_fifo.sv =====
// ----------------------------------------------------------------------------
// fpt_fifo
// Short command queue between the front and the back of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_fifo #(
	parameter int DEPTH = fpt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire fpt_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output fpt_pkg::cmd_t      head,
	output logic               empty
);
	import fpt_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	cmd_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W_Q'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fpt_front.sv =====
// ----------------------------------------------------------------------------
// fpt_front
// Input side: accepts items, runs the window timer, queues the work.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_front #(
	parameter int FAN_CHANNELS = fpt_pkg::FAN_CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fpt_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fpt_pkg::in_item_t in_item,
	output logic                   push,
	output fpt_pkg::cmd_t          push_cmd,
	input  wire logic              q_full
);
	import fpt_pkg::*;

	logic [WIN_W-1:0] timer_q;
	logic [WIN_W-1:0] win_eff;
	logic [WIN_W:0]   tick_next;
	logic             window_end;
	logic             accept;
	logic             chan_ok;
	logic             want_push;

	assign in_stall   = q_full;
	assign accept     = in_valid && !q_full;
	assign win_eff    = (cfg.window_ms == '0) ? WIN_W'(1) : cfg.window_ms;
	assign tick_next  = {1'b0, timer_q} + (WIN_W + 1)'(1);
	assign window_end = (tick_next >= {1'b0, win_eff});
	assign chan_ok    = (in_item.address < ADDR_W'(FAN_CHANNELS));

	always_comb begin
		want_push = 1'b0;
		push_cmd.op = OP_READ;
		unique case (in_item.kind)
			KIND_WRITE: begin
				want_push   = chan_ok;
				push_cmd.op = OP_WRITE;
			end
			KIND_PULSE: begin
				want_push   = chan_ok;
				push_cmd.op = OP_PULSE;
			end
			KIND_TICK: begin
				want_push   = window_end;
				push_cmd.op = OP_WINDOW;
			end
			KIND_READ: begin
				want_push   = 1'b1;
				push_cmd.op = OP_READ;
			end
			default: begin
				want_push   = 1'b0;
				push_cmd.op = OP_READ;
			end
		endcase
		push_cmd.addr = in_item.address;
		push_cmd.pct  = (in_item.write_value > PCT_MAX) ? PCT_W'(PCT_MAX)
			: in_item.write_value[PCT_W-1:0];
	end

	assign push = accept && want_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (accept && in_item.kind == KIND_TICK) begin
			timer_q <= window_end ? '0 : tick_next[WIN_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fpt_back.sv =====
// ----------------------------------------------------------------------------
// fpt_back
// Execution side: setpoints, pulse counters, speed division, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_back #(
	parameter int FAN_CHANNELS = fpt_pkg::FAN_CHANNELS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire fpt_pkg::cfg_t cfg,
	input  wire logic          q_empty,
	input  wire fpt_pkg::cmd_t q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output fpt_pkg::out_item_t out_item
);
	import fpt_pkg::*;

	localparam int CH_W = (FAN_CHANNELS > 1) ? $clog2(FAN_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DUTY  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]        state_q;
	logic [PCT_W-1:0]  setpoint_q   [FAN_CHANNELS];
	logic [CNT_W-1:0]  pulse_cnt_q  [FAN_CHANNELS];
	logic [CNT_W-1:0]  last_speed_q [FAN_CHANNELS];
	logic [CH_W-1:0]   ch_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PCT_W-1:0]  pct_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [CNT_W-1:0]  quot_q;
	logic [3:0]        bit_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              slot_free;
	logic              emit;
	out_item_t         emit_item;
	logic [CH_W-1:0]   head_ch;
	logic [1:0]        rd_ch;
	logic              rd_ok;
	logic [VALUE_W-1:0] rd_data;
	logic [PPR_W-1:0]  ppr_eff;
	logic [WIN_W-1:0]  win_eff;
	logic [27:0]       duty_prod;
	logic [DEN_W:0]    trial;
	logic              trial_ge;
	logic [DEN_W:0]    trial_sub;
	logic              last_ch;

	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign head_ch = q_head.addr[CH_W-1:0];
	assign rd_ch   = q_head.addr[1:0];
	assign rd_ok   = ({1'b0, rd_ch} < ADDR_W'(FAN_CHANNELS));
	assign ppr_eff = (cfg.pulses_per_rev == '0) ? PPR_W'(1) : cfg.pulses_per_rev;
	assign win_eff = (cfg.window_ms == '0) ? WIN_W'(1) : cfg.window_ms;

	assign duty_prod = 28'(prod_q) * 28'(DUTY_RECIP);
	assign trial     = {rem_q, quot_q[CNT_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign last_ch   = (ch_q == CH_W'(FAN_CHANNELS - 1));

	always_comb begin
		rd_data = '0;
		if (rd_ok) begin
			if (!q_head.addr[2]) begin
				rd_data = VALUE_W'(setpoint_q[rd_ch[CH_W-1:0]]);
			end else begin
				rd_data = last_speed_q[rd_ch[CH_W-1:0]];
			end
		end
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && !q_empty) begin
			q_pop = (q_head.op != OP_READ) || slot_free;
		end
	end

	always_comb begin
		emit = 1'b0;
		emit_item = '0;
		priority if (state_q == ST_IDLE && q_pop && q_head.op == OP_READ) begin
			emit = 1'b1;
			emit_item.report_kind        = REPORT_READ;
			emit_item.channel_or_address = q_head.addr;
			emit_item.data               = rd_data;
			emit_item.last               = 1'b1;
		end else if (state_q == ST_DUTY && slot_free) begin
			emit = 1'b1;
			emit_item.report_kind        = REPORT_DUTY;
			emit_item.channel_or_address = addr_q;
			emit_item.data               = VALUE_W'(pct_q);
			emit_item.pwm_duty           = duty_prod[DUTY_SHIFT +: DUTY_W];
			emit_item.last               = 1'b1;
		end else if (state_q == ST_EMIT && slot_free) begin
			emit = 1'b1;
			emit_item.report_kind        = REPORT_SPEED;
			emit_item.channel_or_address = ADDR_W'(ch_q);
			emit_item.data               = quot_q;
			emit_item.last               = last_ch;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
		if (q_pop && q_head.op == OP_WRITE) begin
			addr_q <= q_head.addr;
			pct_q  <= q_head.pct;
			prod_q <= ({q_head.pct, 8'd0} - PROD_W'(q_head.pct)) + PROD_W'(DUTY_ROUND);
		end
		unique case (state_q)
			ST_LOAD: begin
				num_q <= NUM_W'(pulse_cnt_q[ch_q]) * NUM_W'(RPM_SCALE);
				den_q <= DEN_W'(ppr_eff) * DEN_W'(win_eff);
			end
			ST_CHECK: begin
				if (DEN_W'(num_q[NUM_W-1:CNT_W]) >= den_q) begin
					quot_q <= '1;
				end else begin
					rem_q  <= DEN_W'(num_q[NUM_W-1:CNT_W]);
					quot_q <= num_q[CNT_W-1:0];
				end
			end
			ST_DIV: begin
				rem_q  <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
				quot_q <= {quot_q[CNT_W-2:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FAN_CHANNELS; i++) begin
				setpoint_q[i]   <= '0;
				pulse_cnt_q[i]  <= '0;
				last_speed_q[i] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.op)
							OP_WRITE: begin
								setpoint_q[head_ch] <= q_head.pct;
								state_q <= ST_DUTY;
							end
							OP_PULSE: begin
								if (pulse_cnt_q[head_ch] != '1) begin
									pulse_cnt_q[head_ch] <= pulse_cnt_q[head_ch] + 1'b1;
								end
							end
							OP_WINDOW: begin
								ch_q    <= '0;
								state_q <= ST_LOAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DUTY: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					bit_q <= '0;
					if (DEN_W'(num_q[NUM_W-1:CNT_W]) >= den_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 4'd15) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						last_speed_q[ch_q] <= quot_q;
						pulse_cnt_q[ch_q]  <= '0;
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/fan_report_checker.sv =====
// ----------------------------------------------------------------------------
// fan_report_checker
// Watches the item, report and register channels of the fan controller. It
// keeps its own copy of setpoints, pulse counters, speeds, window timer and
// registers, works out the reports each accepted item must cause and compares
// every report transfer, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module fan_report_checker #(
	parameter int FAN_CHANNELS = fpt_pkg::FAN_CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  fpt_pkg::in_item_t                in_item,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  fpt_pkg::out_item_t               out_item,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [fpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpt_pkg::VALUE_W-1:0]      cfg_data,
	output int                               fail_count,
	output int                               reports_due
);
	import fpt_pkg::*;

	logic [PCT_W-1:0] setpoint [4];
	logic [CNT_W-1:0] pulses [4];
	logic [CNT_W-1:0] speed [4];
	logic [WIN_W-1:0] win_timer;
	logic [PPR_W-1:0] ppr;
	logic [WIN_W-1:0] win_len;
	out_item_t        due_reports [$];
	out_item_t        want;
	int               fails;
	bit               all_ok;

	function automatic out_item_t report(input logic [KIND_W-1:0] kind,
			input logic [ADDR_W-1:0] ch, input logic [VALUE_W-1:0] data,
			input logic [DUTY_W-1:0] duty, input logic last);
		out_item_t r;
		r.report_kind        = kind;
		r.channel_or_address = ch;
		r.data               = data;
		r.pwm_duty           = duty;
		r.last               = last;
		return r;
	endfunction

	task automatic compute_reports(input in_item_t it);
		logic [VALUE_W-1:0] pct;
		logic [VALUE_W-1:0] rd;
		logic [16:0]        next_tick;
		logic [63:0]        ppr_eff;
		logic [63:0]        win_eff;
		logic [63:0]        rpm;
		case (it.kind)
			KIND_WRITE: begin
				if (it.address < FAN_CHANNELS) begin
					pct = (it.write_value > 16'd100) ? 16'd100 : it.write_value;
					setpoint[it.address[1:0]] = pct[PCT_W-1:0];
					due_reports.push_back(report(REPORT_DUTY, it.address, pct,
						8'((32'(pct) * 255 + 50) / 100), 1'b1));
				end
			end
			KIND_PULSE: begin
				if (it.address < FAN_CHANNELS && pulses[it.address[1:0]] != 16'hFFFF)
					pulses[it.address[1:0]] = pulses[it.address[1:0]] + 16'd1;
			end
			KIND_TICK: begin
				ppr_eff   = (ppr == '0) ? 64'd1 : 64'(ppr);
				win_eff   = (win_len == '0) ? 64'd1 : 64'(win_len);
				next_tick = {1'b0, win_timer} + 17'd1;
				if (64'(next_tick) < win_eff) begin
					win_timer = next_tick[15:0];
				end else begin
					win_timer = '0;
					for (int i = 0; i < FAN_CHANNELS; i++) begin
						rpm = (64'(pulses[i]) * 64'd60000) / (ppr_eff * win_eff);
						if (rpm > 64'hFFFF)
							rpm = 64'hFFFF;
						speed[i]  = rpm[15:0];
						pulses[i] = '0;
						due_reports.push_back(report(REPORT_SPEED, 3'(i), rpm[15:0], 8'd0,
							1'(i == FAN_CHANNELS - 1)));
					end
				end
			end
			KIND_READ: begin
				rd = '0;
				if (it.address < 4) begin
					if (it.address < FAN_CHANNELS)
						rd = 16'(setpoint[it.address[1:0]]);
				end else if (32'(it.address) - 4 < FAN_CHANNELS) begin
					rd = speed[it.address[1:0]];
				end
				due_reports.push_back(report(REPORT_READ, it.address, rd, 8'd0, 1'b1));
			end
		endcase
	endtask

	function automatic bit field_ok(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		return exp_v == act_v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				setpoint[i] = '0;
				pulses[i]   = '0;
				speed[i]    = '0;
			end
			win_timer = '0;
			ppr       = PPR_RESET;
			win_len   = WIN_RESET;
			due_reports.delete();
			reports_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PULSES_PER_REV: ppr = cfg_data[PPR_W-1:0];
					CFG_WINDOW_MS:      win_len = cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				compute_reports(in_item);
			if (out_valid && !out_stall) begin
				if (due_reports.size() == 0) begin
					$display("%0t: report with none due, expected nothing, actual %h",
						$time, out_item);
					fails++;
				end else begin
					want   = due_reports.pop_front();
					all_ok = field_ok("report_kind", want.report_kind, out_item.report_kind)
						& field_ok("channel_or_address", want.channel_or_address,
							out_item.channel_or_address)
						& field_ok("data", want.data, out_item.data)
						& field_ok("pwm_duty", want.pwm_duty, out_item.pwm_duty)
						& field_ok("last", want.last, out_item.last);
					if (!all_ok)
						fails++;
				end
			end
			reports_due <= due_reports.size();
		end
	end

	initial fails = 0;
	assign fail_count = fails;

endmodule

// ===== tb/tb_fan_pwm_tacho_controller.sv =====
// ----------------------------------------------------------------------------
// tb_fan_pwm_tacho_controller
// Drives register writes, tacho pulses, millisecond ticks and register reads
// into the fan controller under several register settings, with random gaps
// and report stalls, one long report hold-off and drains between phases.
// The checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_fan_pwm_tacho_controller;
	import fpt_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 21;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VALUE_W-1:0]   cfg_data;
	int                   fail_count;
	int                   reports_due;
	bit                   hold_go;
	int                   cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	fan_pwm_tacho_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fan_report_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.reports_due (reports_due)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	task automatic push_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic [VALUE_W-1:0] value, input int gap);
		in_item  <= {kind, addr, value};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold input until every due report has gone out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [PPR_W-1:0] ppr, input logic [WIN_W-1:0] win);
		for (int r = 0; r < 2; r++) begin
			cfg_index <= (r == 0) ? CFG_PULSES_PER_REV : CFG_WINDOW_MS;
			cfg_data  <= (r == 0) ? 16'(ppr) : win;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(input bit gapless);
		int                 sel;
		logic [KIND_W-1:0]  k;
		logic [ADDR_W-1:0]  a;
		logic [VALUE_W-1:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 25)
			k = KIND_WRITE;
		else if (sel < 55)
			k = KIND_PULSE;
		else if (sel < 80)
			k = KIND_TICK;
		else
			k = KIND_READ;
		a = 3'($urandom_range(0, 7));
		if (k != KIND_READ && $urandom_range(0, 9) < 8)
			a = 3'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 16'($urandom_range(0, 100));
			4, 5, 6, 7: v = 16'($urandom_range(0, 65535));
			8:          v = 16'hFFFF;
			default:    v = 16'($urandom_range(99, 102));
		endcase
		push_item(k, a, v, gapless ? 0 : pick_gap());
	endtask

	// report side: random stalls, one long hold-off on request
	initial begin
		int r;
		int len;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 10) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 40);
				end else if (r < 17) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(10, 50);
				end
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [PPR_W-1:0] ph_ppr;
		logic [WIN_W-1:0] ph_win;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PULSES_PER_REV;
		cfg_data  = '0;
		hold_go   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, clamping, rounding, ignored writes and pulses
		push_item(KIND_READ,  3'd0, 16'd0,     0);
		push_item(KIND_READ,  3'd7, 16'hFFFF,  0);
		push_item(KIND_WRITE, 3'd0, 16'd0,     pick_gap());
		push_item(KIND_WRITE, 3'd1, 16'd100,   0);
		push_item(KIND_WRITE, 3'd2, 16'd101,   0);
		push_item(KIND_WRITE, 3'd3, 16'hFFFF,  pick_gap());
		push_item(KIND_WRITE, 3'd3, 16'd70,    0);
		push_item(KIND_WRITE, 3'd2, 16'd90,    0);
		push_item(KIND_WRITE, 3'd1, 16'd50,    0);
		push_item(KIND_WRITE, 3'd4, 16'd50,    0);
		push_item(KIND_WRITE, 3'd7, 16'hFFFF,  pick_gap());
		repeat (3) push_item(KIND_PULSE, 3'd0, 16'h5A5A, 0);
		push_item(KIND_PULSE, 3'd5, 16'd0,     0);
		push_item(KIND_PULSE, 3'd3, 16'd0,     0);
		push_item(KIND_TICK,  3'd0, 16'd0,     0);
		push_item(KIND_READ,  3'd3, 16'd0,     0);
		push_item(KIND_READ,  3'd2, 16'd0,     0);
		settle();

		// one-tick window: speed overflow saturates
		set_regs(4'd1, 16'd1);
		push_item(KIND_TICK,  3'd2, 16'd0,     0);
		push_item(KIND_READ,  3'd4, 16'd0,     0);
		push_item(KIND_READ,  3'd7, 16'd0,     0);
		push_item(KIND_READ,  3'd5, 16'd0,     0);
		settle();

		// zero registers act as one
		set_regs(4'd0, 16'd0);
		push_item(KIND_PULSE, 3'd1, 16'd0,     0);
		push_item(KIND_TICK,  3'd1, 16'd0,     0);
		push_item(KIND_READ,  3'd5, 16'd0,     0);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       begin ph_ppr = 4'd1;  ph_win = 16'd1; end
				1:       begin ph_ppr = 4'd8;  ph_win = 16'd3; end
				2:       begin ph_ppr = 4'd4;  ph_win = 16'd2; end
				3:       begin ph_ppr = 4'd15; ph_win = 16'd6; end
				default: begin ph_ppr = 4'd0;  ph_win = 16'd0; end
			endcase
			set_regs(ph_ppr, ph_win);
			if (ph == 2) begin
				// fill the block while reports are held off
				hold_go = 1'b1;
				while (hold_go)
					@(posedge clk);
				repeat (PHASE_ITEMS) random_item(1'b1);
			end else begin
				repeat (PHASE_ITEMS) begin
					random_item(1'b0);
					if ($urandom_range(0, 11) == 0)
						drain();
				end
			end
			settle();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
